/* design/mpbm_pkg.sv */
// Shared types and constants for the multi-pattern byte matcher.
package mpbm_pkg;

  localparam int unsigned CountW   = 16;
  localparam int unsigned MarkW    = 32;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_BUILD  = 2'd2,
    REQ_SEARCH = 2'd3
  } req_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ZROW,
    S_INS_RD,
    S_INS_CHK,
    S_INS_FIN,
    S_CNT_WR,
    S_SR_RD,
    S_SR_CHK,
    S_SR_FL,
    S_OC_RD,
    S_OC_CHK,
    S_SR_FIN,
    S_B_POP,
    S_B_PAR,
    S_B_CRD,
    S_B_CCHK,
    S_B_FW,
    S_B_FC,
    S_B_FF,
    S_EMIT
  } state_e;

endpackage

/* design/mpbm_ram.sv */
// Single-port RAM with registered read data.
module mpbm_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned WIDTH  = 10,
  parameter int unsigned ADDR_W = 10
) (
  input  logic              clk_i,
  input  logic [ADDR_W-1:0] addr_i,
  input  logic              we_i,
  input  logic [WIDTH-1:0]  wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/multi_pattern_byte_matcher.sv */
// Aho-Corasick multi-pattern byte matcher: top level and sequencer.
//
// Patterns are inserted byte by byte into a trie held in RAM, a build request
// computes failure links breadth first, and text bytes are then walked
// through the automaton; the final text byte returns the number of pattern
// occurrences (saturating at 65535, each trie node counted once per text).
// One item is handled at a time and in_ready_o is low while it is at work.
// All work goes through one small sequencer with single-port RAMs (child
// table, failure links, pattern counts, visit marks, build queue), each with
// registered read data. A clear sweeps the root row to zero, and a pattern
// byte that allocates a new node sweeps that node's child row to zero; a text
// byte follows failure links and then the output chain, adding the counts of
// nodes not yet seen by this text. After reset a clearing pass zeroes the
// root row before the first transfer is accepted. A result that the consumer
// has not yet taken holds in the output register; the next result waits
// until it drains.
module multi_pattern_byte_matcher #(
  parameter int unsigned MAX_NODES     = 1024,
  parameter int unsigned ALPHABET_SIZE = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mpbm_pkg::CountW-1:0] match_count_o,
  output logic                       status_o
);

  import mpbm_pkg::*;

  localparam int unsigned NW = $clog2(MAX_NODES);
  localparam int unsigned AW = $clog2(ALPHABET_SIZE);
  localparam logic [NW:0]   MaxN  = (NW+1)'(MAX_NODES);
  localparam logic [AW-1:0] LastC = AW'(ALPHABET_SIZE - 1);

  // Reduce a byte modulo the alphabet size by restoring subtraction.
  function automatic logic [AW-1:0] fold_sym(input logic [7:0] b);
    logic [15:0] r;
    logic [15:0] m;
    r = {8'd0, b};
    for (int k = 7; k >= 0; k--) begin
      m = 16'(ALPHABET_SIZE) << k;
      if (r >= m) r = r - m;
    end
    return r[AW-1:0];
  endfunction

  state_e state_q, state_d;

  logic [NW:0]   nc_q, nc_d;       // allocated node count
  logic [NW-1:0] cur_q, cur_d;     // shared cursor
  logic [NW-1:0] p_q, p_d;
  logic [NW-1:0] f_q, f_d;         // failure walk / output chain
  logic [NW-1:0] qn_q, qn_d;       // child being linked during build
  logic [NW-1:0] row_q, row_d;     // row being swept
  logic [AW-1:0] ci_q, ci_d;       // symbol counter
  logic [AW-1:0] sym_q, sym_d;
  logic          last_q, last_d;
  logic          zret_q, zret_d;   // sweep returns to insert finish
  logic          drop_q, drop_d;
  logic [CountW-1:0] sum_q, sum_d;
  logic [MarkW-1:0]  txt_q, txt_d;
  logic [NW:0]   head_q, head_d, tail_q, tail_d;
  logic [CountW-1:0] pend_cnt_q, pend_cnt_d;
  logic          pend_st_q, pend_st_d;
  logic          out_valid_q, out_valid_d;
  logic [CountW-1:0] out_cnt_q;
  logic          out_st_q;
  logic          out_load;

  // RAM ports
  logic [NW+AW-1:0]  ch_addr;
  logic              ch_we;
  logic [NW-1:0]     ch_wd, ch_rd;
  logic [NW-1:0]     fl_addr, fl_wd, fl_rd;
  logic              fl_we;
  logic [NW-1:0]     cn_addr;
  logic              cn_we;
  logic [CountW-1:0] cn_wd, cn_rd;
  logic [NW-1:0]     mk_addr;
  logic              mk_we;
  logic [MarkW-1:0]  mk_wd, mk_rd;
  logic [NW-1:0]     qu_addr, qu_wd, qu_rd;
  logic              qu_we;

  logic [CountW:0]   sum_ext;
  logic [MarkW-1:0]  txt_inc;

  mpbm_ram #(.DEPTH(MAX_NODES * (2 ** AW)), .WIDTH(NW), .ADDR_W(NW+AW)) u_child (
    .clk_i, .addr_i(ch_addr), .we_i(ch_we), .wdata_i(ch_wd), .rdata_o(ch_rd)
  );
  mpbm_ram #(.DEPTH(MAX_NODES), .WIDTH(NW), .ADDR_W(NW)) u_fail (
    .clk_i, .addr_i(fl_addr), .we_i(fl_we), .wdata_i(fl_wd), .rdata_o(fl_rd)
  );
  mpbm_ram #(.DEPTH(MAX_NODES), .WIDTH(CountW), .ADDR_W(NW)) u_count (
    .clk_i, .addr_i(cn_addr), .we_i(cn_we), .wdata_i(cn_wd), .rdata_o(cn_rd)
  );
  mpbm_ram #(.DEPTH(MAX_NODES), .WIDTH(MarkW), .ADDR_W(NW)) u_mark (
    .clk_i, .addr_i(mk_addr), .we_i(mk_we), .wdata_i(mk_wd), .rdata_o(mk_rd)
  );
  mpbm_ram #(.DEPTH(MAX_NODES), .WIDTH(NW), .ADDR_W(NW)) u_queue (
    .clk_i, .addr_i(qu_addr), .we_i(qu_we), .wdata_i(qu_wd), .rdata_o(qu_rd)
  );

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign match_count_o = out_cnt_q;
  assign status_o      = out_st_q;

  assign sum_ext  = {1'b0, sum_q} + {1'b0, cn_rd};
  assign txt_inc  = txt_q + MarkW'(1);
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    nc_d       = nc_q;
    cur_d      = cur_q;
    p_d        = p_q;
    f_d        = f_q;
    qn_d       = qn_q;
    row_d      = row_q;
    ci_d       = ci_q;
    sym_d      = sym_q;
    last_d     = last_q;
    zret_d     = zret_q;
    drop_d     = drop_q;
    sum_d      = sum_q;
    txt_d      = txt_q;
    head_d     = head_q;
    tail_d     = tail_q;
    pend_cnt_d = pend_cnt_q;
    pend_st_d  = pend_st_q;

    ch_addr = {cur_q, sym_q};
    ch_we   = 1'b0;
    ch_wd   = '0;
    fl_addr = f_q;
    fl_we   = 1'b0;
    fl_wd   = '0;
    cn_addr = cur_q;
    cn_we   = 1'b0;
    cn_wd   = '0;
    mk_addr = f_q;
    mk_we   = 1'b0;
    mk_wd   = txt_q;
    qu_addr = head_q[NW-1:0];
    qu_we   = 1'b0;
    qu_wd   = qn_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sym_d  = fold_sym(data_byte_i);
          last_d = last_i;
          unique case (req_e'(req_type_i))
            REQ_CLEAR: begin
              nc_d   = (NW+1)'(1);
              cur_d  = '0;
              sum_d  = '0;
              txt_d  = MarkW'(1);
              drop_d = 1'b0;
              row_d  = '0;
              ci_d   = '0;
              zret_d = 1'b0;
              state_d = S_ZROW;
            end
            REQ_INSERT: begin
              state_d = drop_q ? S_INS_FIN : S_INS_RD;
            end
            REQ_BUILD: begin
              // seed the queue with the root
              qu_addr = '0;
              qu_wd   = '0;
              qu_we   = 1'b1;
              fl_addr = '0;
              fl_wd   = '0;
              fl_we   = 1'b1;
              head_d  = '0;
              tail_d  = (NW+1)'(1);
              state_d = S_B_POP;
            end
            REQ_SEARCH: begin
              p_d     = cur_q;
              state_d = S_SR_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // Zero one child row and initialise the node's other fields.
      S_ZROW: begin
        ch_addr = {row_q, ci_q};
        ch_we   = 1'b1;
        ch_wd   = '0;
        fl_addr = row_q;
        fl_we   = 1'b1;
        cn_addr = row_q;
        cn_we   = 1'b1;
        mk_addr = row_q;
        mk_we   = 1'b1;
        mk_wd   = '0;
        if (ci_q == LastC) begin
          state_d = zret_q ? S_INS_FIN : S_IDLE;
        end else begin
          ci_d = ci_q + AW'(1);
        end
      end

      S_INS_RD: begin
        ch_addr = {cur_q, sym_q};
        state_d = S_INS_CHK;
      end

      S_INS_CHK: begin
        if (ch_rd != '0) begin
          cur_d   = ch_rd;
          state_d = S_INS_FIN;
        end else if (nc_q >= MaxN) begin
          drop_d  = 1'b1;
          state_d = S_INS_FIN;
        end else begin
          ch_addr = {cur_q, sym_q};
          ch_we   = 1'b1;
          ch_wd   = nc_q[NW-1:0];
          cur_d   = nc_q[NW-1:0];
          row_d   = nc_q[NW-1:0];
          nc_d    = nc_q + (NW+1)'(1);
          ci_d    = '0;
          zret_d  = 1'b1;
          state_d = S_ZROW;
        end
      end

      S_INS_FIN: begin
        cn_addr = cur_q;
        if (!last_q) begin
          state_d = S_IDLE;
        end else if (drop_q) begin
          pend_cnt_d = '0;
          pend_st_d  = 1'b1;
          drop_d     = 1'b0;
          cur_d      = '0;
          state_d    = S_EMIT;
        end else begin
          state_d = S_CNT_WR;
        end
      end

      S_CNT_WR: begin
        cn_addr    = cur_q;
        cn_we      = (cn_rd != CountMax);
        cn_wd      = cn_rd + CountW'(1);
        pend_cnt_d = '0;
        pend_st_d  = 1'b0;
        cur_d      = '0;
        state_d    = S_EMIT;
      end

      S_SR_RD: begin
        ch_addr = {p_q, sym_q};
        state_d = S_SR_CHK;
      end

      S_SR_CHK: begin
        if (ch_rd != '0 || p_q == '0) begin
          cur_d   = ch_rd;
          f_d     = ch_rd;
          state_d = S_OC_RD;
        end else begin
          fl_addr = p_q;
          state_d = S_SR_FL;
        end
      end

      S_SR_FL: begin
        p_d     = fl_rd;
        state_d = S_SR_RD;
      end

      // Walk the output chain until the root or a node this text has seen.
      S_OC_RD: begin
        fl_addr = f_q;
        cn_addr = f_q;
        mk_addr = f_q;
        state_d = (f_q == '0) ? S_SR_FIN : S_OC_CHK;
      end

      S_OC_CHK: begin
        if (mk_rd != txt_q) begin
          sum_d   = sum_ext[CountW] ? CountMax : sum_ext[CountW-1:0];
          mk_addr = f_q;
          mk_we   = 1'b1;
          f_d     = fl_rd;
          state_d = S_OC_RD;
        end else begin
          state_d = S_SR_FIN;
        end
      end

      S_SR_FIN: begin
        if (last_q) begin
          pend_cnt_d = sum_q;
          pend_st_d  = 1'b0;
          sum_d      = '0;
          cur_d      = '0;
          txt_d      = (txt_inc == '0) ? MarkW'(1) : txt_inc;
          state_d    = S_EMIT;
        end else begin
          state_d = S_IDLE;
        end
      end

      S_B_POP: begin
        qu_addr = head_q[NW-1:0];
        if (head_q < tail_q) begin
          head_d  = head_q + (NW+1)'(1);
          state_d = S_B_PAR;
        end else begin
          cur_d   = '0;
          sum_d   = '0;
          drop_d  = 1'b0;
          state_d = S_IDLE;
        end
      end

      S_B_PAR: begin
        p_d     = qu_rd;
        ci_d    = '0;
        state_d = S_B_CRD;
      end

      S_B_CRD: begin
        ch_addr = {p_q, ci_q};
        state_d = S_B_CCHK;
      end

      S_B_CCHK: begin
        qn_d = ch_rd;
        if (ch_rd == '0 || {1'b0, ch_rd} >= nc_q) begin
          ci_d    = ci_q + AW'(1);
          state_d = (ci_q == LastC) ? S_B_POP : S_B_CRD;
        end else if (p_q == '0) begin
          fl_addr = ch_rd;
          fl_wd   = '0;
          fl_we   = 1'b1;
          qu_addr = tail_q[NW-1:0];
          qu_wd   = ch_rd;
          if (tail_q < MaxN) begin
            qu_we  = 1'b1;
            tail_d = tail_q + (NW+1)'(1);
          end
          ci_d    = ci_q + AW'(1);
          state_d = (ci_q == LastC) ? S_B_POP : S_B_CRD;
        end else begin
          fl_addr = p_q;
          state_d = S_B_FF;
        end
      end

      S_B_FF: begin
        f_d     = fl_rd;
        state_d = S_B_FW;
      end

      S_B_FW: begin
        ch_addr = {f_q, ci_q};
        state_d = S_B_FC;
      end

      S_B_FC: begin
        if (f_q == '0 || ch_rd != '0) begin
          fl_addr = qn_q;
          fl_wd   = ch_rd;
          fl_we   = 1'b1;
          qu_addr = tail_q[NW-1:0];
          qu_wd   = qn_q;
          if (tail_q < MaxN) begin
            qu_we  = 1'b1;
            tail_d = tail_q + (NW+1)'(1);
          end
          ci_d    = ci_q + AW'(1);
          state_d = (ci_q == LastC) ? S_B_POP : S_B_CRD;
        end else begin
          fl_addr = f_q;
          state_d = S_B_FF;
        end
      end

      // Hold the result until the output register is free.
      S_EMIT: begin
        if (out_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ZROW;
      nc_q        <= (NW+1)'(1);
      cur_q       <= '0;
      row_q       <= '0;
      ci_q        <= '0;
      zret_q      <= 1'b0;
      drop_q      <= 1'b0;
      sum_q       <= '0;
      txt_q       <= MarkW'(1);
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nc_q        <= nc_d;
      cur_q       <= cur_d;
      row_q       <= row_d;
      ci_q        <= ci_d;
      zret_q      <= zret_d;
      drop_q      <= drop_d;
      sum_q       <= sum_d;
      txt_q       <= txt_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    f_q        <= f_d;
    qn_q       <= qn_d;
    sym_q      <= sym_d;
    last_q     <= last_d;
    pend_cnt_q <= pend_cnt_d;
    pend_st_q  <= pend_st_d;
    if (out_load) begin
      out_cnt_q <= pend_cnt_q;
      out_st_q  <= pend_st_q;
    end
  end

endmodule

/* design/mpbm_checker.sv */
// Port-level checks for the multi-pattern byte matcher, bound to the top level.
module mpbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] match_count_o,
  input logic        status_o
);

  // A waiting result holds until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(match_count_o) && $stable(status_o))
    else $error("result dropped or changed while stalled");

  // A dropped-pattern report never carries a count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> match_count_o == 16'd0)
    else $error("status and count both set");

  // One item at a time: after a transfer the input side closes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

  // A result appears only after some input transfer has been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o || !$past(in_ready_o))
    else $error("result without work");

endmodule

bind multi_pattern_byte_matcher mpbm_checker u_mpbm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .match_count_o (match_count_o),
  .status_o      (status_o)
);

/* tb/sv/multi_pattern_byte_matcher_tb.sv */
// Self-checking testbench for the multi-pattern byte matcher.
module multi_pattern_byte_matcher_tb;
  import mpbm_pkg::*;

  localparam int unsigned NodeMax  = 1024;
  localparam int unsigned CycleCap = 20000000;
  localparam int unsigned HoldOff  = 3000;

  // Holds a shadow automaton and the queue of match counts it predicts.
  class match_scoreboard;
    typedef struct packed {
      logic [CountW-1:0] count;
      logic              status;
    } match_res_t;

    logic [9:0]  child [NodeMax][256];
    int unsigned fail_link [NodeMax];
    int unsigned pat_cnt [NodeMax];
    int unsigned seen_in [NodeMax];
    int unsigned walk_q [NodeMax];
    int unsigned n_nodes, cur, sum, text_no;
    bit          dropped;
    match_res_t  pending_q[$];

    function new();
      clear_trie();
    endfunction

    function void init_node(int unsigned n);
      for (int c = 0; c < 256; c++) child[n][c] = '0;
      fail_link[n] = 0;
      pat_cnt[n]   = 0;
      seen_in[n]   = 0;
    endfunction

    function void clear_trie();
      n_nodes = 1;
      init_node(0);
      cur     = 0;
      sum     = 0;
      text_no = 1;
      dropped = 0;
    endfunction

    function void build_links();
      int unsigned head, tail, p, q, f;
      head = 0;
      tail = 1;
      walk_q[0] = 0;
      fail_link[0] = 0;
      while (head < tail) begin
        p = walk_q[head];
        head++;
        for (int c = 0; c < 256; c++) begin
          q = child[p][c];
          if (q == 0 || q >= n_nodes) continue;
          if (p == 0) begin
            fail_link[q] = 0;
          end else begin
            f = fail_link[p];
            while (f != 0 && child[f][c] == 0) f = fail_link[f];
            fail_link[q] = child[f][c];
          end
          if (tail < NodeMax) begin
            walk_q[tail] = q;
            tail++;
          end
        end
      end
      cur     = 0;
      sum     = 0;
      dropped = 0;
    endfunction

    function void add_pattern_byte(logic [7:0] b);
      int unsigned n;
      if (dropped) return;
      n = child[cur][b];
      if (n == 0) begin
        if (n_nodes >= NodeMax) begin
          dropped = 1;
          return;
        end
        n = n_nodes;
        n_nodes++;
        init_node(n);
        child[cur][b] = n[9:0];
      end
      cur = n;
    endfunction

    function void walk_text_byte(logic [7:0] b);
      int unsigned p, o;
      p = cur;
      while (p != 0 && child[p][b] == 0) p = fail_link[p];
      p = child[p][b];
      cur = p;
      o = p;
      // Follow the output chain, counting each node once per text.
      while (o != 0 && seen_in[o] != text_no) begin
        sum += pat_cnt[o];
        if (sum > 65535) sum = 65535;
        seen_in[o] = text_no;
        o = fail_link[o];
      end
    endfunction

    // Advance the shadow automaton by one accepted transfer.
    function void note_transfer(req_e kind, logic [7:0] b, logic fin);
      match_res_t r;
      case (kind)
        REQ_CLEAR: clear_trie();
        REQ_BUILD: build_links();
        REQ_INSERT: begin
          add_pattern_byte(b);
          if (fin) begin
            if (!dropped && pat_cnt[cur] < 65535) pat_cnt[cur]++;
            r.count  = '0;
            r.status = dropped;
            pending_q.push_back(r);
            dropped = 0;
            cur = 0;
          end
        end
        default: begin
          walk_text_byte(b);
          if (fin) begin
            r.count  = sum[CountW-1:0];
            r.status = 1'b0;
            pending_q.push_back(r);
            sum = 0;
            cur = 0;
            text_no++;
            if (text_no == 0) text_no = 1;
          end
        end
      endcase
    endfunction

    function bit check_result(logic [CountW-1:0] cnt, logic st, output string msg);
      match_res_t r;
      if (pending_q.size() == 0) begin
        $sformat(msg, "unexpected result count=%0d status=%0d", cnt, st);
        return 0;
      end
      r = pending_q.pop_front();
      if (r.count !== cnt || r.status !== st) begin
        $sformat(msg, "result count=%0d status=%0d, predicted count=%0d status=%0d",
                 cnt, st, r.count, r.status);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  req_e              req_type_i = REQ_CLEAR;
  logic [7:0]        data_byte_i = '0;
  logic              last_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [CountW-1:0] match_count_o;
  logic              status_o;

  match_scoreboard sb = new();
  int unsigned     n_fail = 0;
  int unsigned     n_sent = 0;
  int unsigned     cycle_no = 0;
  bit              hold_req = 0;
  bit              no_idle = 0;

  multi_pattern_byte_matcher i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .data_byte_i  (data_byte_i),
    .last_i       (last_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .match_count_o(match_count_o),
    .status_o     (status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bail out if the block hangs; the cap sits far above the slowest clean run.
  always @(posedge clk_i) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no > CycleCap) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report(string msg);
    $display("MISMATCH @%0d: %s", cycle_no, msg);
    n_fail++;
  endtask

  // Mostly short gaps, now and then a long one; none at all in burst stretches.
  function automatic int unsigned idle_len();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Favour a tiny alphabet so patterns overlap; full random bytes keep every bit busy.
  function automatic logic [7:0] pick_byte();
    logic [7:0] tiny [4] = '{8'h00, 8'h01, 8'hFF, 8'h80};
    if ($urandom_range(0, 3) != 0) return tiny[$urandom_range(0, 1 + $urandom_range(0, 2))];
    return 8'($urandom);
  endfunction

  // Offer one transfer and hold it until the block takes it. Entered at a rising edge.
  task automatic send(req_e kind, logic [7:0] b, logic fin);
    int unsigned gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= kind;
    data_byte_i <= b;
    last_i      <= fin;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic send_string(req_e kind, string s);
    for (int i = 0; i < s.len(); i++) send(kind, s[i], i == s.len() - 1);
  endtask

  task automatic send_random_seq(req_e kind, int unsigned len);
    for (int i = 0; i < len; i++) send(kind, pick_byte(), i == len - 1);
  endtask

  // Note each accepted transfer in the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) sb.note_transfer(req_type_i, data_byte_i, last_i);
  end

  // Check each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (!sb.check_result(match_count_o, status_o, msg)) report(msg);
    end
  end

  // Receiver: random stalls, plus one long hold-off on request so the block backs up.
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (HoldOff) @(posedge clk_i);
      end
      stall = idle_len();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned waited;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: classic pattern set, duplicate pattern, byte extremes, odd orderings.
    send(REQ_CLEAR, 8'hFF, 1'b1);
    send_string(REQ_INSERT, "he");
    send_string(REQ_INSERT, "she");
    send_string(REQ_INSERT, "hers");
    send_string(REQ_INSERT, "he");
    send(REQ_BUILD, 8'hA5, 1'b1);
    send_string(REQ_SEARCH, "ushers");
    // Hold the receiver off while a run of short result-bearing items backs up.
    hold_req = 1;
    send(REQ_INSERT, 8'hFF, 1'b1);
    send(REQ_INSERT, 8'h00, 1'b1);
    send(REQ_SEARCH, 8'h00, 1'b0);
    send(REQ_SEARCH, 8'hFF, 1'b1);
    send(REQ_BUILD, 8'h00, 1'b0);
    send(REQ_SEARCH, "s", 1'b0);
    send(REQ_INSERT, "h", 1'b0);
    send(REQ_SEARCH, "e", 1'b1);
    send_string(REQ_SEARCH, "hehe");
    send(REQ_SEARCH, "h", 1'b1);
    send(REQ_INSERT, 8'h01, 1'b1);
    send(REQ_SEARCH, 8'h01, 1'b1);

    // Fill the node table without a build, overflowing it, then search the bare trie.
    send(REQ_CLEAR, 8'h00, 1'b0);
    for (int p = 0; p < 18; p++) begin
      for (int i = 0; i < 64; i++) send(REQ_INSERT, 8'($urandom), i == 63);
    end
    send(REQ_INSERT, 8'h00, 1'b1);
    send_random_seq(REQ_SEARCH, 6);
    send(REQ_CLEAR, 8'h00, 1'b0);

    // Random phases: mostly well-formed insert/build/search rounds, some noise.
    while (n_sent < 1800) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 2) == 0) send(REQ_CLEAR, 8'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 6)) send_random_seq(REQ_INSERT, $urandom_range(1, 4));
      if ($urandom_range(0, 9) != 0) send(REQ_BUILD, 8'($urandom), 1'($urandom));
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 7) == 0) begin
          send(req_e'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
        end else begin
          send_random_seq(REQ_SEARCH, $urandom_range(1, 15));
        end
      end
    end
    no_idle = 0;
    in_valid_i <= 1'b0;

    waited = 0;
    while (sb.pending_q.size() != 0 && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (600) @(posedge clk_i);
    if (sb.pending_q.size() != 0) report($sformatf("%0d results never arrived",
                                                   sb.pending_q.size()));
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
